// File: rtl/core/hamming_136_128_block_decoder_macros.svh
// assertion shorthands for the block decoder checker
`ifndef HAMMING_136_128_BLOCK_DECODER_MACROS_SVH
`define HAMMING_136_128_BLOCK_DECODER_MACROS_SVH

// same-cycle implication, off during reset
`define HBD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbd same-cycle check failed");

// next-cycle implication, off during reset
`define HBD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbd next-cycle check failed");

`endif

// File: rtl/core/hbd_pkg.sv
package hbd_pkg;

  localparam int DATA_BYTES_DEF = 16;
  localparam int Q_DEPTH        = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic bit is_pow2(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // 1-based code position of the d-th data bit (d from 0)
  function automatic int data_pos(int d);
    int n;
    int res;
    n   = -1;
    res = 0;
    for (int p = 1; p < 256; p++) begin
      if (!is_pow2(p)) begin
        n++;
        if (n == d && res == 0) begin
          res = p;
        end
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/hbd_front.sv
module hbd_front #(
  parameter int DATA_BYTES = hbd_pkg::DATA_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  hbd_pkg::q_stat_t                q_stat,
  output logic                            push,
  output logic [8*(DATA_BYTES+1)-1:0]     push_blk,
  output logic [7:0]                      push_syn
);
  import hbd_pkg::*;

  localparam int BITS  = 8 * (DATA_BYTES + 1);
  localparam int CNT_W = $clog2(DATA_BYTES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       syn_r, syn_nxt;
  logic [7:0]       contrib;
  logic [7:0]       buf_r [DATA_BYTES];
  logic             at_last;
  logic             accept;

  assign at_last   = (cnt_r == CNT_W'(DATA_BYTES));
  assign in_tready = !(at_last && q_stat.full);
  assign accept    = in_tvalid && in_tready;

  // xor of the positions of the set bits of this byte
  always_comb begin
    contrib = '0;
    for (int k = 0; k < 8; k++) begin
      if (in_tdata[7-k]) begin
        contrib = contrib ^ (8'({cnt_r, 3'b000}) + 8'(k + 1));
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    syn_nxt = syn_r;
    if (accept) begin
      if (at_last) begin
        cnt_nxt = '0;
        syn_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        syn_nxt = syn_r ^ contrib;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      syn_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      syn_r <= syn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      if (accept && cnt_r == CNT_W'(i)) begin
        buf_r[i] <= in_tdata;
      end
    end
  end

  assign push     = accept && at_last;
  assign push_syn = syn_r ^ contrib;

  for (genvar i = 0; i < DATA_BYTES; i++) begin : g_blk
    assign push_blk[BITS-1-8*i -: 8] = buf_r[i];
  end
  assign push_blk[7:0] = in_tdata;

endmodule

// File: rtl/core/hbd_queue.sv
module hbd_queue #(
  parameter int WIDTH = 8 * (hbd_pkg::DATA_BYTES_DEF + 1) + 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  pop_data,
  output hbd_pkg::q_stat_t  q_stat
);
  import hbd_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/hbd_back.sv
module hbd_back #(
  parameter int DATA_BYTES = hbd_pkg::DATA_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hbd_pkg::q_stat_t                q_stat,
  input  logic [8*(DATA_BYTES+1)+7:0]     pop_data,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  output logic                            out_tlast,
  output logic [8:0]                      out_tuser
);
  import hbd_pkg::*;

  localparam int BITS  = 8 * (DATA_BYTES + 1);
  localparam int DAT_W = 8 * DATA_BYTES;
  localparam int CNT_W = $clog2(DATA_BYTES + 1);

  logic [BITS-1:0]  blk_in, flip, fixed;
  logic [7:0]       syn_in;
  logic             unc_in;
  logic [DAT_W-1:0] dat;
  logic [DAT_W-1:0] dat_r, dat_nxt;
  logic [7:0]       syn_r, syn_nxt;
  logic             unc_r, unc_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;

  assign blk_in = pop_data[BITS+7:8];
  assign syn_in = pop_data[7:0];
  assign unc_in = (syn_in > 8'(BITS));

  // a syndrome naming a position flips that bit
  for (genvar j = 0; j < BITS; j++) begin : g_flip
    assign flip[j] = (syn_in == 8'(BITS - j));
  end
  assign fixed = blk_in ^ flip;

  // drop the parity positions
  for (genvar d = 0; d < DAT_W; d++) begin : g_dat
    assign dat[DAT_W-1-d] = fixed[BITS - data_pos(d)];
  end

  assign out_tvalid = (left_r != '0);
  assign out_tlast  = (left_r == CNT_W'(1));
  assign out_tdata  = dat_r[DAT_W-1 -: 8];
  assign out_tuser  = {unc_r, syn_r};

  assign pop = !q_stat.empty && (!out_tvalid || (out_tlast && out_tready));

  always_comb begin
    dat_nxt  = dat_r;
    syn_nxt  = syn_r;
    unc_nxt  = unc_r;
    left_nxt = left_r;
    if (pop) begin
      dat_nxt  = dat;
      syn_nxt  = syn_in;
      unc_nxt  = unc_in;
      left_nxt = CNT_W'(DATA_BYTES);
    end else if (out_tvalid && out_tready) begin
      dat_nxt  = {dat_r[DAT_W-9:0], 8'h00};
      left_nxt = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dat_r <= dat_nxt;
    syn_r <= syn_nxt;
    unc_r <= unc_nxt;
  end

endmodule

// File: rtl/core/hamming_136_128_block_decoder.sv
// single-error-correcting hamming decoder over blocks of DATA_BYTES+1 code bytes
// input stream: in_tvalid/in_tready/in_tdata carries one code byte per request,
// blocks back to back with no framing; the 17th byte (default size) closes a block
// output stream: DATA_BYTES corrected data bytes per block, msb first;
// out_tlast marks the final byte, out_tuser gives the syndrome and the
// uncorrectable flag, the same on every byte of a block
// a closed block is queued, then loaded into the back's output register
// throughput: one code byte per cycle while in_tready, DATA_BYTES out per block
// the front collects bytes and the syndrome, a two-block queue feeds the back,
// which corrects the block and shifts out one byte per cycle from its register
// when the receiver stalls the output byte holds; the front keeps taking bytes
// and only holds off the closing byte of a block while two blocks are queued
// reset empties the queue and drops any partial block; no clearing pass
module hamming_136_128_block_decoder #(
  parameter int DATA_BYTES = hbd_pkg::DATA_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // code_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // data_byte
  output logic       out_tlast,   // last_of_block
  output logic [8:0] out_tuser    // error_position [7:0], uncorrectable [8]
);
  import hbd_pkg::*;

  localparam int BITS = 8 * (DATA_BYTES + 1);

  q_stat_t          q_stat;
  logic             push;
  logic             pop;
  logic [BITS-1:0]  push_blk;
  logic [7:0]       push_syn;
  logic [BITS+7:0]  pop_data;

  hbd_front #(.DATA_BYTES(DATA_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_blk  (push_blk),
    .push_syn  (push_syn)
  );

  hbd_queue #(.WIDTH(BITS + 8)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_blk, push_syn}),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  hbd_back #(.DATA_BYTES(DATA_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/core/hbd_checker.sv
`include "hamming_136_128_block_decoder_macros.svh"

module hbd_checker #(
  parameter int DATA_BYTES = hbd_pkg::DATA_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic [8:0] out_tuser
);

  localparam int BITS = 8 * (DATA_BYTES + 1);

  // flag agrees with the syndrome range
  `HBD_ASSERT_IMPL(a_unc_range, out_tvalid, out_tuser[8] == (out_tuser[7:0] > 8'(BITS)))

  // a block keeps streaming with one syndrome until its last byte
  `HBD_ASSERT_NEXT(a_block_cont, out_tvalid && out_tready && !out_tlast, out_tvalid && $stable(out_tuser))

  // nothing pending downstream means the front cannot be blocked
  `HBD_ASSERT_IMPL(a_idle_ready, !out_tvalid, in_tready)

  // stalled output holds
  `HBD_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

endmodule

bind hamming_136_128_block_decoder hbd_checker #(.DATA_BYTES(DATA_BYTES)) u_hbd_checker (.*);
